/* hw/rtl/ksm_pkg.sv */
// ----------------------------------------------------------------------------
// ksm_pkg
// Types, sizes and codes shared by the k-way sorted merge block.
// ----------------------------------------------------------------------------
package ksm_pkg;

   localparam int NUM_LISTS  = 8;
   localparam int LIST_DEPTH = 256;

   localparam int LIST_W   = $clog2(NUM_LISTS);
   localparam int LEAVES   = 1 << LIST_W;
   localparam int POS_W    = $clog2(LIST_DEPTH);
   localparam int CNT_W    = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W   = LIST_W + POS_W;
   localparam int STORE_WORDS = 1 << ADDR_W;
   localparam int VALUE_W  = 32;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [LIST_W-1:0]         list_idx_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] list_id;
      value_type  value;
   } req_type;

   typedef struct packed {
      value_type  merged_value;
      logic [2:0] source_list;
      logic       got_value;
      logic       all_empty;
      logic       list_full;
   } rsp_type;

   // winner of the head comparison
   typedef struct packed {
      logic         found;
      list_idx_type list;
      value_type    value;
   } sel_type;

   typedef enum logic {
      ST_IDLE,
      ST_REFILL
   } state_type;

endpackage

/* hw/rtl/k_way_sorted_merge.sv */
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Merge of up to NUM_LISTS sorted lists held in one element RAM.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Every item gives one
// result, shown on rsp_data for one cycle with rsp_valid high, in the cycle
// after the transfer. The receiver cannot hold a result off. Load, clear and
// no-op items, and a pop that finds every list exhausted, leave busy low, so
// another item can follow them directly. A pop that returns a value also
// refills a head: the current heads, cached in registers, go through a
// compare tree in the transfer cycle, then busy is high for one cycle while
// the next element of the winning list comes back from the single read port
// of the element RAM. No clearing pass is needed after reset.
module k_way_sorted_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ksm_pkg::req_type req_data,
   output logic             rsp_valid,
   output ksm_pkg::rsp_type rsp_data
);

   import ksm_pkg::*;

   state_type    state_ff, state_in;
   count_type    fill_ff [NUM_LISTS];
   count_type    fill_in [NUM_LISTS];
   count_type    pos_ff  [NUM_LISTS];
   count_type    pos_in  [NUM_LISTS];
   value_type    head_ff [NUM_LISTS];
   value_type    head_in [NUM_LISTS];
   list_idx_type refill_list_ff, refill_list_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [NUM_LISTS-1:0] head_valid;
   sel_type      sel;
   logic         accept;
   logic         lid_in_range;
   list_idx_type lid;

   logic         ram_wr_en;
   addr_type     ram_wr_addr;
   logic         ram_rd_en;
   addr_type     ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   always_comb begin
      for (int i = 0; i < NUM_LISTS; i++) begin
         head_valid[i] = pos_ff[i] < fill_ff[i];
      end
   end

   ksm_head_select u_head_select (
      .head_value (head_ff),
      .head_valid (head_valid),
      .sel        (sel)
   );

   ksm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data.value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept       = start && !busy;
   assign lid_in_range = 32'(req_data.list_id) < NUM_LISTS;
   assign lid          = LIST_W'(req_data.list_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            fill_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
      end
      head_ff        <= head_in;
      refill_list_ff <= refill_list_in;
      rsp_ff         <= rsp_in;
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      head_in        = head_ff;
      refill_list_in = refill_list_ff;
      rsp_in         = '0;
      rsp_valid_in   = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = {lid, fill_ff[lid][POS_W-1:0]};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = {sel.list, POS_W'(pos_ff[sel.list] + CNT_W'(1))};
      busy           = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req_data.op)
                  OP_LOAD: begin
                     if (!lid_in_range || fill_ff[lid] == CNT_W'(LIST_DEPTH)) begin
                        rsp_in.list_full = 1'b1;
                     end else begin
                        ram_wr_en    = 1'b1;
                        fill_in[lid] = fill_ff[lid] + CNT_W'(1);
                        // list had no unread head: new value becomes the head
                        if (pos_ff[lid] == fill_ff[lid]) begin
                           head_in[lid] = req_data.value;
                        end
                     end
                  end
                  OP_POP: begin
                     if (sel.found) begin
                        rsp_in.merged_value = sel.value;
                        rsp_in.source_list  = 3'(sel.list);
                        rsp_in.got_value    = 1'b1;
                        pos_in[sel.list]    = pos_ff[sel.list] + CNT_W'(1);
                        ram_rd_en           = 1'b1;
                        refill_list_in      = sel.list;
                        state_in            = ST_REFILL;
                     end else begin
                        rsp_in.all_empty = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     for (int i = 0; i < NUM_LISTS; i++) begin
                        fill_in[i] = '0;
                        pos_in[i]  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_REFILL: begin
            // read data is stale when the list ran dry; the head is then invalid
            busy                    = 1'b1;
            head_in[refill_list_ff] = ram_rd_data;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_refill_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REFILL |=> state_ff == ST_IDLE)
      else $error("refill lasted more than one cycle");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $countones({rsp_data.got_value, rsp_data.all_empty, rsp_data.list_full}) <= 1)
      else $error("more than one result flag set");

   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_POP && sel.found) |=>
         (rsp_valid && rsp_data.got_value && busy))
      else $error("pop with a valid head gave no value");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.op == OP_POP && head_valid == '0) |=>
         (rsp_valid && rsp_data.all_empty && !busy))
      else $error("pop with no heads did not report empty");

endmodule

/* hw/rtl/ksm_ram.sv */
// ----------------------------------------------------------------------------
// ksm_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ksm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ksm_head_select.sv */
// ----------------------------------------------------------------------------
// ksm_head_select
// Binary compare tree over the cached list heads; ties go to the lower list.
// ----------------------------------------------------------------------------
module ksm_head_select (
   input  ksm_pkg::value_type             head_value [ksm_pkg::NUM_LISTS],
   input  logic [ksm_pkg::NUM_LISTS-1:0]  head_valid,
   output ksm_pkg::sel_type               sel
);

   import ksm_pkg::*;

   logic         node_valid [LIST_W+1][LEAVES];
   value_type    node_value [LIST_W+1][LEAVES];
   list_idx_type node_list  [LIST_W+1][LEAVES];

   always_comb begin
      logic take_right;
      take_right = 1'b0;
      for (int l = 0; l < LEAVES; l++) begin
         if (l < NUM_LISTS) begin
            node_valid[0][l] = head_valid[l];
            node_value[0][l] = head_value[l];
         end else begin
            node_valid[0][l] = 1'b0;
            node_value[0][l] = '0;
         end
         node_list[0][l] = LIST_W'(l);
      end
      for (int lv = 1; lv <= LIST_W; lv++) begin
         for (int n = 0; n < LEAVES; n++) begin
            if (n < (LEAVES >> lv)) begin
               // right side only wins when strictly smaller
               take_right = node_valid[lv-1][2*n+1] &&
                            (!node_valid[lv-1][2*n] ||
                             node_value[lv-1][2*n+1] < node_value[lv-1][2*n]);
               if (take_right) begin
                  node_valid[lv][n] = 1'b1;
                  node_value[lv][n] = node_value[lv-1][2*n+1];
                  node_list[lv][n]  = node_list[lv-1][2*n+1];
               end else begin
                  node_valid[lv][n] = node_valid[lv-1][2*n];
                  node_value[lv][n] = node_value[lv-1][2*n];
                  node_list[lv][n]  = node_list[lv-1][2*n];
               end
            end else begin
               node_valid[lv][n] = 1'b0;
               node_value[lv][n] = '0;
               node_list[lv][n]  = '0;
            end
         end
      end
      sel.found = node_valid[LIST_W][0];
      sel.value = node_value[LIST_W][0];
      sel.list  = node_list[LIST_W][0];
   end

endmodule
